/* rtl/first_order_lowpass_filter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the first-order low-pass filter
// Checks that are sampled on clk, with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef FIRST_ORDER_LOWPASS_FILTER_ASSERT_SVH
`define FIRST_ORDER_LOWPASS_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FLPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLPF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLPF_ASSERT(lbl, prop, msg)
`define FLPF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

/* rtl/flpf_pkg.sv */
// ----------------------------------------------------------------------------
// flpf_pkg
// Widths, codes, types and helpers shared by the low-pass filter modules.
// ----------------------------------------------------------------------------
package flpf_pkg;

  localparam int SAMPLE_W  = 32;              // signed Q16.16 sample
  localparam int FRAC_W    = 16;              // fraction bits of the weight
  localparam int WEIGHT_W  = FRAC_W + 1;      // weight up to and including 1.0
  localparam int TICK_W    = 32;
  localparam int IN_DATA_W = SAMPLE_W + TICK_W;
  localparam int DEN_W     = TICK_W + 1;      // time constant plus elapsed
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int ACC_W     = DIFF_W + 1;      // upper half of the product
  localparam int ALU_W     = ACC_W + 1;
  localparam int CNT_W     = $clog2(WEIGHT_W);
  localparam int CFG_W     = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;
  localparam logic [CNT_W-1:0]    CNT_LAST   = CNT_W'(WEIGHT_W - 1);

  typedef enum logic [1:0] {
    REG_TAU_TICKS,
    REG_FIXED_WEIGHT,
    REG_USE_FIXED,
    REG_FILTER_ENABLE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_DEN,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TICK_W-1:0]   tau_ticks;
    logic [WEIGHT_W-1:0] fixed_weight;
    logic                use_fixed_weight;
    logic                filter_enable;
  } cfg_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  function automatic logic [ALU_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v);
    return {{(ALU_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  function automatic logic [ALU_W-1:0] sext_diff(input logic [DIFF_W-1:0] v);
    return {{(ALU_W - DIFF_W){v[DIFF_W-1]}}, v};
  endfunction

  function automatic logic [ALU_W-1:0] sext_acc(input logic [ACC_W-1:0] v);
    return {{(ALU_W - ACC_W){v[ACC_W-1]}}, v};
  endfunction

  // Weights above 1.0 are held at 1.0.
  function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] w);
    return (w > WEIGHT_ONE) ? WEIGHT_ONE : w;
  endfunction

  // Clamps a wide signed sum into the signed sample range.
  function automatic logic [SAMPLE_W-1:0] clamp_sample(input logic [ALU_W-1:0] v);
    logic [ALU_W-SAMPLE_W:0] top;
    logic [SAMPLE_W-1:0]     res;
    top = v[ALU_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      res = v[SAMPLE_W-1:0];
    end else if (v[ALU_W-1]) begin
      res = {1'b1, {(SAMPLE_W - 1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W - 1){1'b1}}};
    end
    return res;
  endfunction

endpackage

/* rtl/flpf_alu.sv */
// ----------------------------------------------------------------------------
// flpf_alu
// The one adder/subtractor that the sequencer shares between difference,
// denominator, division, multiplication and final update steps.
// ----------------------------------------------------------------------------
module flpf_alu (
  input  flpf_pkg::alu_req_t          req,
  output logic [flpf_pkg::ALU_W-1:0]  res
);

  logic [flpf_pkg::ALU_W-1:0] b_op;

  assign b_op = req.sub ? ~req.b : req.b;
  assign res  = req.a + b_op + flpf_pkg::ALU_W'(req.sub);

endmodule

/* rtl/flpf_core.sv */
// ----------------------------------------------------------------------------
// flpf_core
// Sequencer and datapath registers: weight by restoring division or fixed, product
// by shift-and-add, then the update of the stored value, all on the shared adder.
// ----------------------------------------------------------------------------
`include "first_order_lowpass_filter_assert.svh"

module flpf_core (
  input  logic                           clk,
  input  logic                           rst,
  input  flpf_pkg::cfg_t                 cfg,
  input  logic                           start,
  input  logic                           start_cmd,
  input  logic [flpf_pkg::SAMPLE_W-1:0]  start_sample,
  input  logic [flpf_pkg::TICK_W-1:0]    start_elapsed,
  input  logic                           take,
  output flpf_pkg::core_stat_t           stat,
  output logic [flpf_pkg::SAMPLE_W-1:0]  result
);

  flpf_pkg::state_t state;
  flpf_pkg::state_t state_next;

  logic [flpf_pkg::SAMPLE_W-1:0] x_reg;
  logic [flpf_pkg::TICK_W-1:0]   dt_reg;
  logic [flpf_pkg::DIFF_W-1:0]   diff;
  logic [flpf_pkg::DEN_W-1:0]    den;
  logic [flpf_pkg::DEN_W-1:0]    rem;
  logic [flpf_pkg::WEIGHT_W-1:0] dsh;
  logic [flpf_pkg::WEIGHT_W-1:0] q;
  logic [flpf_pkg::ACC_W-1:0]    acc_hi;
  logic [flpf_pkg::WEIGHT_W-1:0] acc_lo;
  logic [flpf_pkg::CNT_W-1:0]    cnt;
  logic [flpf_pkg::SAMPLE_W-1:0] sv;

  flpf_pkg::alu_req_t          alu_req;
  logic [flpf_pkg::ALU_W-1:0]  alu_res;
  logic                        bypass;
  logic                        den_zero;
  logic                        ge;
  logic                        cnt_last;

  flpf_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign bypass   = start_cmd || !cfg.filter_enable;
  assign den_zero = (alu_res[flpf_pkg::DEN_W-1:0] == '0);
  assign ge       = !alu_res[flpf_pkg::ALU_W-1];
  assign cnt_last = (cnt == flpf_pkg::CNT_LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      flpf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = bypass ? flpf_pkg::ST_DONE : flpf_pkg::ST_DIFF;
        end
      end
      flpf_pkg::ST_DIFF: begin
        state_next = cfg.use_fixed_weight ? flpf_pkg::ST_MUL : flpf_pkg::ST_DEN;
      end
      flpf_pkg::ST_DEN: begin
        state_next = den_zero ? flpf_pkg::ST_MUL : flpf_pkg::ST_DIV;
      end
      flpf_pkg::ST_DIV: begin
        if (cnt_last) begin
          state_next = flpf_pkg::ST_MUL;
        end
      end
      flpf_pkg::ST_MUL: begin
        if (cnt_last) begin
          state_next = flpf_pkg::ST_SUM;
        end
      end
      flpf_pkg::ST_SUM: begin
        state_next = flpf_pkg::ST_DONE;
      end
      flpf_pkg::ST_DONE: begin
        if (take) begin
          state_next = flpf_pkg::ST_IDLE;
        end
      end
      default: state_next = flpf_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req   = '0;
    stat.idle = 1'b0;
    stat.done = 1'b0;
    unique case (state)
      flpf_pkg::ST_IDLE: begin
        stat.idle = 1'b1;
      end
      flpf_pkg::ST_DIFF: begin
        alu_req.sub = 1'b1;
        alu_req.a   = flpf_pkg::sext_sample(x_reg);
        alu_req.b   = flpf_pkg::sext_sample(sv);
      end
      flpf_pkg::ST_DEN: begin
        alu_req.a = flpf_pkg::ALU_W'(cfg.tau_ticks);
        alu_req.b = flpf_pkg::ALU_W'(dt_reg);
      end
      flpf_pkg::ST_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = flpf_pkg::ALU_W'({rem, dsh[flpf_pkg::WEIGHT_W-1]});
        alu_req.b   = flpf_pkg::ALU_W'(den);
      end
      flpf_pkg::ST_MUL: begin
        alu_req.a = flpf_pkg::sext_acc(acc_hi);
        alu_req.b = q[0] ? flpf_pkg::sext_diff(diff) : '0;
      end
      flpf_pkg::ST_SUM: begin
        alu_req.a = flpf_pkg::sext_sample(sv);
        alu_req.b = {acc_hi, acc_lo[flpf_pkg::WEIGHT_W-1]};
      end
      flpf_pkg::ST_DONE: begin
        stat.done = 1'b1;
      end
      default: begin
        stat.idle = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flpf_pkg::ST_IDLE;
      cnt   <= '0;
      sv    <= '0;
    end else begin
      state <= state_next;
      case (state)
        flpf_pkg::ST_IDLE: begin
          if (start) begin
            x_reg  <= start_sample;
            dt_reg <= start_elapsed;
            if (bypass) begin
              sv <= start_sample;
            end
          end
        end
        flpf_pkg::ST_DIFF: begin
          diff   <= alu_res[flpf_pkg::DIFF_W-1:0];
          cnt    <= '0;
          acc_hi <= '0;
          q      <= flpf_pkg::sat_weight(cfg.fixed_weight);
        end
        flpf_pkg::ST_DEN: begin
          // The quotient has no bits above the unit place, so the division
          // starts with the upper part of the dividend already brought down.
          den <= alu_res[flpf_pkg::DEN_W-1:0];
          rem <= flpf_pkg::DEN_W'(dt_reg >> 1);
          dsh <= {dt_reg[0], {(flpf_pkg::WEIGHT_W - 1){1'b0}}};
          q   <= flpf_pkg::WEIGHT_ONE;
          cnt <= '0;
        end
        flpf_pkg::ST_DIV: begin
          rem <= ge ? alu_res[flpf_pkg::DEN_W-1:0]
                    : {rem[flpf_pkg::DEN_W-2:0], dsh[flpf_pkg::WEIGHT_W-1]};
          dsh <= dsh << 1;
          q   <= {q[flpf_pkg::WEIGHT_W-2:0], ge};
          cnt <= cnt_last ? '0 : cnt + 1'b1;
        end
        flpf_pkg::ST_MUL: begin
          acc_hi <= {alu_res[flpf_pkg::ACC_W-1], alu_res[flpf_pkg::ACC_W-1:1]};
          acc_lo <= {alu_res[0], acc_lo[flpf_pkg::WEIGHT_W-1:1]};
          q      <= q >> 1;
          cnt    <= cnt_last ? '0 : cnt + 1'b1;
        end
        flpf_pkg::ST_SUM: begin
          sv <= flpf_pkg::clamp_sample(alu_res);
        end
        default: begin
        end
      endcase
    end
  end

  assign result = sv;

  `FLPF_ASSERT_RST(a_reset_idle, rst |=> (state == flpf_pkg::ST_IDLE), "core not idle after reset")
  `FLPF_ASSERT(a_rem_below_den, (state == flpf_pkg::ST_DIV) |-> (rem < den), "partial remainder not below denominator")
  `FLPF_ASSERT(a_weight_max_one, (state == flpf_pkg::ST_MUL && cnt == '0) |-> (q <= flpf_pkg::WEIGHT_ONE), "weight above one")
  `FLPF_ASSERT(a_bypass_store, (state == flpf_pkg::ST_IDLE && start && bypass) |=> (state == flpf_pkg::ST_DONE && sv == $past(start_sample)), "load or bypass did not store the sample")

endmodule

/* rtl/first_order_lowpass_filter.sv */
// One item is in work at a time. A load or bypass item goes straight to done.
// Filtering takes the difference, then with the fixed weight the 17 multiply
// steps; with the derived weight it forms the denominator and runs 17 division
// steps (none when time constant plus elapsed is zero) before them, then the sum,
// all on the shared adder. The next request is taken after the result moves out.
// Reset clears the stored value to zero and loads the register defaults.
// ----------------------------------------------------------------------------
// first_order_lowpass_filter
// Exponential moving average over signed Q16.16 samples with a fixed or
// time-derived weight, a load request and a bypass mode.
// ----------------------------------------------------------------------------
module first_order_lowpass_filter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [flpf_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [flpf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // sample, elapsed
  input  logic                                s_axis_tuser,  // cmd
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [flpf_pkg::SAMPLE_W-1:0]       m_axis_tdata   // filtered
);

  flpf_pkg::cfg_t        cfg;
  flpf_pkg::core_stat_t  stat;
  logic [flpf_pkg::SAMPLE_W-1:0] result;
  logic                  start;
  logic                  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tau_ticks        <= '0;
      cfg.fixed_weight     <= '0;
      cfg.use_fixed_weight <= 1'b0;
      cfg.filter_enable    <= 1'b1;
    end else if (cfg_we) begin
      unique case (flpf_pkg::cfg_reg_t'(cfg_index))
        flpf_pkg::REG_TAU_TICKS:     cfg.tau_ticks <= cfg_data[flpf_pkg::TICK_W-1:0];
        flpf_pkg::REG_FIXED_WEIGHT:  cfg.fixed_weight <= cfg_data[flpf_pkg::WEIGHT_W-1:0];
        flpf_pkg::REG_USE_FIXED:     cfg.use_fixed_weight <= cfg_data[0];
        flpf_pkg::REG_FILTER_ENABLE: cfg.filter_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = stat.idle;
  assign start         = s_axis_tvalid && stat.idle;
  // The finished value moves to the output register once it is free.
  assign take          = stat.done && (!m_axis_tvalid || m_axis_tready);

  flpf_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .start         (start),
    .start_cmd     (s_axis_tuser),
    .start_sample  (s_axis_tdata[flpf_pkg::SAMPLE_W-1:0]),
    .start_elapsed (s_axis_tdata[flpf_pkg::IN_DATA_W-1:flpf_pkg::SAMPLE_W]),
    .take          (take),
    .stat          (stat),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= result;
    end
  end

endmodule

/* bench/first_order_lowpass_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_order_lowpass_filter_test
// Drives filter, load and bypass requests into the low-pass filter under
// changing register settings and handshake pressure, predicts each stored
// value in a scoreboard and compares every returned sample against it.
// ----------------------------------------------------------------------------
module first_order_lowpass_filter_test;

  localparam int LIMIT_CYCLES = 500000;
  localparam int ITEMS_PER_SETTING = 53;

  // Tracks the smoothed value and the register copy, and queues the value
  // the block should return for every accepted request.
  class ema_scoreboard;
    logic [31:0]        tau_ticks;
    logic [16:0]        fixed_weight;
    logic               use_fixed_weight;
    logic               filter_enable;
    logic signed [31:0] smoothed;
    logic signed [31:0] expected_filtered[$];
    int failures;
    int requests;
    int loads;
    int bypassed;
    int outputs_seen;

    function new();
      tau_ticks        = '0;
      fixed_weight     = '0;
      use_fixed_weight = 1'b0;
      filter_enable    = 1'b1;
      smoothed         = '0;
    endfunction

    function void set_register(flpf_pkg::cfg_reg_t idx, logic [31:0] val);
      case (idx)
        flpf_pkg::REG_TAU_TICKS:     tau_ticks        = val;
        flpf_pkg::REG_FIXED_WEIGHT:  fixed_weight     = val[16:0];
        flpf_pkg::REG_USE_FIXED:     use_fixed_weight = val[0];
        flpf_pkg::REG_FILTER_ENABLE: filter_enable    = val[0];
        default: ;
      endcase
    endfunction

    function void advance_average(bit cmd, logic signed [31:0] smp, logic [31:0] el);
      longint unsigned den;
      longint          weight;
      longint          diff;
      longint          prod;
      longint          next;
      requests++;
      if (cmd) loads++;
      if (cmd || !filter_enable) begin
        if (!filter_enable) bypassed++;
        smoothed = smp;
      end else begin
        if (use_fixed_weight) begin
          weight = (fixed_weight > flpf_pkg::WEIGHT_ONE)
                   ? (longint'(1) << flpf_pkg::FRAC_W)
                   : longint'({47'd0, fixed_weight});
        end else begin
          den = {32'd0, tau_ticks} + {32'd0, el};
          if (den == 0) begin
            weight = longint'(1) << flpf_pkg::FRAC_W;
          end else begin
            weight = longint'(({32'd0, el} << flpf_pkg::FRAC_W) / den);
          end
        end
        diff = longint'(smp) - longint'(smoothed);
        prod = weight * diff;
        // Arithmetic shift of a signed value rounds towards minus infinity.
        next = longint'(smoothed) + (prod >>> flpf_pkg::FRAC_W);
        if (next > 64'sh7FFF_FFFF) next = 64'sh7FFF_FFFF;
        if (next < -64'sh8000_0000) next = -64'sh8000_0000;
        smoothed = next[31:0];
      end
      expected_filtered.push_back(smoothed);
    endfunction

    function void check_output(logic signed [31:0] got);
      logic signed [31:0] want;
      outputs_seen++;
      if (expected_filtered.size() == 0) begin
        $error("filtered: expected nothing, got %0d", got);
        failures++;
      end else begin
        want = expected_filtered.pop_front();
        if (got !== want) begin
          $error("filtered: expected %0d, got %0d", want, got);
          failures++;
        end
      end
    endfunction

    function int pending();
      return expected_filtered.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // sample, elapsed
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // filtered

  ema_scoreboard board;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int settings_applied;

  first_order_lowpass_filter dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_output(m_axis_tdata);
    end
  end

  task automatic send_request(input bit cmd, input logic [31:0] smp, input logic [31:0] el);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {el, smp};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.advance_average(cmd, smp, el);
  endtask

  // Drops the request line and waits until the block has returned everything.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input flpf_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    board.set_register(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic pick_settings();
    logic [31:0] tc;
    logic [16:0] fw;
    case ($urandom_range(3))
      0: tc = '0;
      1: tc = '1;
      2: tc = $urandom_range(5000);
      default: tc = $urandom;
    endcase
    case ($urandom_range(4))
      0: fw = '0;
      1: fw = 17'd65536;
      2: fw = 17'($urandom_range(131071));
      default: fw = 17'($urandom_range(65536));
    endcase
    write_register(flpf_pkg::REG_TAU_TICKS, tc);
    write_register(flpf_pkg::REG_FIXED_WEIGHT, {15'd0, fw});
    write_register(flpf_pkg::REG_USE_FIXED, {31'd0, 1'($urandom_range(1))});
    // Bypass is kept rare so that most requests exercise the filter path.
    write_register(flpf_pkg::REG_FILTER_ENABLE, {31'd0, 1'($urandom_range(5) != 0)});
    settings_applied++;
  endtask

  task automatic random_requests(input int count);
    bit          cmd;
    logic [31:0] smp;
    logic [31:0] el;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(9) == 0);
      case ($urandom_range(5))
        0: smp = 32'h7FFF_FFFF;
        1: smp = 32'h8000_0000;
        2: smp = 32'($urandom_range(131071)) - 32'd65536;
        default: smp = $urandom;
      endcase
      case ($urandom_range(4))
        0: el = '0;
        1: el = '1;
        2: el = $urandom_range(2000);
        default: el = $urandom;
      endcase
      send_request(cmd, smp, el);
    end
  endtask

  initial begin
    board          = new();
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = flpf_pkg::REG_TAU_TICKS;
    cfg_data       = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settings_applied = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Register defaults: derived weight with a zero time constant.
    send_request(1'b0, 32'h7FFF_FFFF, 32'd0);
    send_request(1'b0, 32'h8000_0000, 32'd0);
    send_request(1'b1, 32'd0, 32'd0);
    send_request(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b1, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();
    write_register(flpf_pkg::REG_TAU_TICKS, 32'hFFFF_FFFF);
    send_request(1'b0, 32'h7FFF_FFFF, 32'd1);
    send_request(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(1'b0, 32'h1234_5678, 32'h8000_0000);
    drain();
    write_register(flpf_pkg::REG_TAU_TICKS, 32'd1000);
    send_request(1'b0, -32'sd5, 32'd3);
    send_request(1'b0, 32'hC000_1234, 32'd777);
    drain();
    write_register(flpf_pkg::REG_FIXED_WEIGHT, 32'd65536);
    write_register(flpf_pkg::REG_USE_FIXED, 32'd1);
    send_request(1'b0, 32'h7FFF_FFFF, 32'hDEAD_BEEF);
    send_request(1'b0, 32'h8000_0000, 32'd0);
    drain();
    write_register(flpf_pkg::REG_FIXED_WEIGHT, 32'd131071);
    send_request(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    drain();
    write_register(flpf_pkg::REG_FIXED_WEIGHT, 32'd0);
    send_request(1'b0, 32'h8000_0000, 32'hFFFF_FFFF);
    drain();
    write_register(flpf_pkg::REG_FIXED_WEIGHT, 32'd32768);
    send_request(1'b0, 32'hFFFF_FFFF, 32'd5);
    send_request(1'b0, 32'h0000_FFFF, 32'd0);
    drain();
    write_register(flpf_pkg::REG_FILTER_ENABLE, 32'd0);
    send_request(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(1'b1, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(1'b0, 32'd0, 32'd9);
    drain();
    write_register(flpf_pkg::REG_FILTER_ENABLE, 32'd1);
    write_register(flpf_pkg::REG_USE_FIXED, 32'd0);
    write_register(flpf_pkg::REG_TAU_TICKS, 32'd0);
    write_register(flpf_pkg::REG_FIXED_WEIGHT, 32'd0);
    send_request(1'b1, 32'd0, 32'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int chunk = 0; chunk < 4; chunk++) begin
        drain();
        pick_settings();
        random_requests(ITEMS_PER_SETTING);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.pending() != 0) begin
      $error("filtered: %0d expected values never returned", board.pending());
      board.failures++;
    end
    $display("Run covered %0d requests (%0d loads, %0d in bypass) and %0d outputs,",
             board.requests, board.loads, board.bypassed, board.outputs_seen);
    $display("across %0d random register settings and four handshake pressure phases.",
             settings_applied);
    if (board.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
